/* sv/union_find_threshold_merge_defines.svh */
// assertion macros for the union-find merge engine
// used by the top level; expects clk_i and rst_ni in scope
`ifndef UNION_FIND_THRESHOLD_MERGE_DEFINES_SVH
`define UNION_FIND_THRESHOLD_MERGE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define UFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define UFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/uft_pkg.sv */
// shared types and constants for the union-find merge engine
// no dependencies
`default_nettype none

package uft_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
  localparam logic [31:0] K_RESET = 32'd9830400;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    logic [31:0] edge_weight;
    logic [19:0] node_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0] op_echo;
    logic       merged;
    logic [9:0] root_index;
    logic [9:0] segment_label;
  } out_word_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_WRAP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_LOAD_WR,
    DP_FIND_START,
    DP_FIND_UP,
    DP_SAVE_ROOT,
    DP_CMP_READ,
    DP_CMP_WRITE,
    DP_EDGE_RDA,
    DP_EDGE_RDB,
    DP_EDGE_CAP,
    DP_DECIDE,
    DP_APPLY,
    DP_LBL_RD,
    DP_LBL_UPD,
    DP_FINISH
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    sel_b;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       wrap_done;
    logic       div_last;
    logic       up_done;
    logic       x_eq_r;
    logic       roots_eq;
    logic       clr_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/uft_ctrl.sv */
// sequencing state machine for the union-find merge engine
// depends on uft_pkg; drives uft_datapath through dp_ctl_t
`default_nettype none

module uft_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire uft_pkg::dp_stat_t stat_i,
  output uft_pkg::dp_ctl_t      ctl_o
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_WRAP, ST_DIV, ST_LOAD_WR, ST_FIND_START, ST_FIND_UP,
    ST_CMP, ST_CMP_WR, ST_EDGE_CHK, ST_EDGE_RDA, ST_EDGE_RDB, ST_EDGE_CAP,
    ST_DECIDE, ST_APPLY, ST_LBL_RD, ST_LBL_UPD, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    ctl_o.cmd = uft_pkg::DP_NOP;
    ctl_o.sel_b = sel_q;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.cmd = uft_pkg::DP_CLEAR;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.cmd = uft_pkg::DP_CAPTURE;
          state_d   = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (!stat_i.wrap_done) begin
          ctl_o.cmd = uft_pkg::DP_WRAP;
        end else begin
          sel_d = 1'b0;
          case (stat_i.op)
            uft_pkg::OP_LOAD: begin
              ctl_o.cmd = uft_pkg::DP_DIV_INIT;
              state_d   = ST_DIV;
            end
            uft_pkg::OP_EDGE, uft_pkg::OP_QUERY: state_d = ST_FIND_START;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        ctl_o.cmd = uft_pkg::DP_DIV_STEP;
        if (stat_i.div_last) state_d = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        ctl_o.cmd = uft_pkg::DP_LOAD_WR;
        state_d   = ST_DONE;
      end
      ST_FIND_START: begin
        ctl_o.cmd = uft_pkg::DP_FIND_START;
        state_d   = ST_FIND_UP;
      end
      ST_FIND_UP: begin
        ctl_o.cmd = uft_pkg::DP_FIND_UP;
        if (stat_i.up_done) state_d = ST_CMP;
      end
      ST_CMP: begin
        if (stat_i.x_eq_r) begin
          ctl_o.cmd = uft_pkg::DP_SAVE_ROOT;
          if (stat_i.op == uft_pkg::OP_QUERY) begin
            state_d = ST_LBL_RD;
          end else if (!sel_q) begin
            sel_d   = 1'b1;
            state_d = ST_FIND_START;
          end else begin
            state_d = ST_EDGE_CHK;
          end
        end else begin
          ctl_o.cmd = uft_pkg::DP_CMP_READ;
          state_d   = ST_CMP_WR;
        end
      end
      ST_CMP_WR: begin
        ctl_o.cmd = uft_pkg::DP_CMP_WRITE;
        state_d   = ST_CMP;
      end
      ST_EDGE_CHK: begin
        if (stat_i.roots_eq) begin
          state_d = ST_DONE;
        end else begin
          ctl_o.cmd = uft_pkg::DP_EDGE_RDA;
          state_d   = ST_EDGE_RDB;
        end
      end
      ST_EDGE_RDB: begin
        ctl_o.cmd = uft_pkg::DP_EDGE_RDB;
        state_d   = ST_EDGE_CAP;
      end
      ST_EDGE_CAP: begin
        ctl_o.cmd = uft_pkg::DP_EDGE_CAP;
        state_d   = ST_DECIDE;
      end
      ST_DECIDE: begin
        ctl_o.cmd = uft_pkg::DP_DECIDE;
        state_d   = ST_APPLY;
      end
      ST_APPLY: begin
        ctl_o.cmd = uft_pkg::DP_APPLY;
        state_d   = ST_DONE;
      end
      ST_LBL_RD: begin
        ctl_o.cmd = uft_pkg::DP_LBL_RD;
        state_d   = ST_LBL_UPD;
      end
      ST_LBL_UPD: begin
        ctl_o.cmd = uft_pkg::DP_LBL_UPD;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          ctl_o.cmd = uft_pkg::DP_FINISH;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire

/* sv/uft_datapath.sv */
// tables, divider, find walker and result register of the merge engine
// depends on uft_pkg; commanded by uft_ctrl
`default_nettype none

module uft_datapath #(
  parameter int NODE_DEPTH = 1024,
  parameter int RANK_BITS  = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire uft_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output uft_pkg::out_word_t      out_data_o,
  input  wire uft_pkg::dp_ctl_t   ctl_i,
  output uft_pkg::dp_stat_t       stat_o
);

  localparam int IW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam logic [16:0] DEPTH_W = 17'(NODE_DEPTH);
  localparam logic [RANK_BITS-1:0] RANK_MAX = {RANK_BITS{1'b1}};

  // memories
  logic [IW-1:0]        par_mem [NODE_DEPTH];
  logic [RANK_BITS-1:0] rank_mem [NODE_DEPTH];
  logic [31:0]          thr_mem [NODE_DEPTH];
  logic                 lv_mem [NODE_DEPTH];
  logic [9:0]           lb_mem [NODE_DEPTH];

  logic                 par_we, rank_we, thr_we, lv_we, lb_we;
  logic [IW-1:0]        par_waddr, par_raddr, rank_waddr, rank_raddr;
  logic [IW-1:0]        thr_waddr, thr_raddr, lbl_waddr, lbl_raddr;
  logic [IW-1:0]        par_wdata;
  logic [RANK_BITS-1:0] rank_wdata;
  logic [31:0]          thr_wdata;
  logic                 lv_wdata;
  logic [9:0]           lb_wdata;

  logic [IW-1:0]        par_rdata_q;
  logic [RANK_BITS-1:0] rank_rdata_q;
  logic [31:0]          thr_rdata_q;
  logic                 lv_rdata_q;
  logic [9:0]           lb_rdata_q;

  // working registers
  logic [1:0]           op_q;
  logic [9:0]           wa_q, wb_q;
  logic [31:0]          w_q;
  logic [19:0]          size_q;
  logic [IW-1:0]        x_q, r_q, ra_q, rb_q;
  logic [31:0]          quo_q;
  logic [20:0]          rem_q;
  logic [19:0]          dvs_q;
  logic [4:0]           div_cnt_q;
  logic [31:0]          ta_q, tb_q, twin_q;
  logic [RANK_BITS-1:0] rka_q, rkb_q;
  logic                 merged_q, winb_q, inc_q;
  logic [9:0]           label_q;

  // control registers
  logic [31:0]             k_q;
  logic [uft_pkg::CNT_W-1:0] lbl_cnt_q;
  logic [IW-1:0]           clr_cnt_q;
  logic                    out_valid_q;
  uft_pkg::out_word_t      out_data_q;

  logic [IW-1:0] a_idx, b_idx, win_idx, lose_idx;
  logic [20:0]   trial;
  logic          trial_ge;
  logic [32:0]   sum;
  logic          finish;

  assign a_idx    = IW'(wa_q);
  assign b_idx    = IW'(wb_q);
  assign win_idx  = winb_q ? rb_q : ra_q;
  assign lose_idx = winb_q ? ra_q : rb_q;
  assign trial    = {rem_q[19:0], quo_q[31]};
  assign trial_ge = (trial >= {1'b0, dvs_q});
  assign sum      = {1'b0, w_q} + {1'b0, twin_q};
  assign finish   = (ctl_i.cmd == uft_pkg::DP_FINISH);

  // memory port control
  always_comb begin
    par_we = 1'b0;  par_waddr = a_idx;  par_wdata = a_idx;  par_raddr = x_q;
    rank_we = 1'b0; rank_waddr = a_idx; rank_wdata = '0;    rank_raddr = ra_q;
    thr_we = 1'b0;  thr_waddr = a_idx;  thr_wdata = quo_q;  thr_raddr = ra_q;
    lv_we = 1'b0;   lb_we = 1'b0;       lbl_waddr = ra_q;   lbl_raddr = ra_q;
    lv_wdata = 1'b1;
    lb_wdata = lbl_cnt_q[9:0];
    case (ctl_i.cmd)
      uft_pkg::DP_CLEAR: begin
        lv_we     = 1'b1;
        lbl_waddr = clr_cnt_q;
        lv_wdata  = 1'b0;
      end
      uft_pkg::DP_LOAD_WR: begin
        par_we  = 1'b1;
        rank_we = 1'b1;
        thr_we  = 1'b1;
      end
      uft_pkg::DP_FIND_START: par_raddr = ctl_i.sel_b ? b_idx : a_idx;
      uft_pkg::DP_FIND_UP:    par_raddr = par_rdata_q;
      uft_pkg::DP_CMP_READ:   par_raddr = x_q;
      uft_pkg::DP_CMP_WRITE: begin
        par_we    = 1'b1;
        par_waddr = x_q;
        par_wdata = r_q;
      end
      uft_pkg::DP_EDGE_RDA: begin
        rank_raddr = ra_q;
        thr_raddr  = ra_q;
      end
      uft_pkg::DP_EDGE_RDB: begin
        rank_raddr = rb_q;
        thr_raddr  = rb_q;
      end
      uft_pkg::DP_APPLY: begin
        par_we     = merged_q;
        par_waddr  = lose_idx;
        par_wdata  = win_idx;
        thr_we     = merged_q;
        thr_waddr  = win_idx;
        thr_wdata  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        rank_we    = merged_q && inc_q;
        rank_waddr = ra_q;
        rank_wdata = rka_q + RANK_BITS'(1);
      end
      uft_pkg::DP_LBL_UPD: begin
        lv_we = !lv_rdata_q;
        lb_we = !lv_rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_waddr] <= par_wdata;
    par_rdata_q <= par_mem[par_raddr];
    if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
    rank_rdata_q <= rank_mem[rank_raddr];
    if (thr_we) thr_mem[thr_waddr] <= thr_wdata;
    thr_rdata_q <= thr_mem[thr_raddr];
    if (lv_we) lv_mem[lbl_waddr] <= lv_wdata;
    lv_rdata_q <= lv_mem[lbl_raddr];
    if (lb_we) lb_mem[lbl_waddr] <= lb_wdata;
    lb_rdata_q <= lb_mem[lbl_raddr];
  end

  // working registers, no reset
  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      uft_pkg::DP_CAPTURE: begin
        op_q     <= in_data_i.op;
        wa_q     <= in_data_i.node_a;
        wb_q     <= in_data_i.node_b;
        w_q      <= in_data_i.edge_weight;
        size_q   <= in_data_i.node_size;
        merged_q <= 1'b0;
        label_q  <= '0;
        ra_q     <= '0;
      end
      uft_pkg::DP_WRAP: begin
        if ({7'b0, wa_q} >= DEPTH_W) wa_q <= wa_q - 10'(NODE_DEPTH);
        if ({7'b0, wb_q} >= DEPTH_W) wb_q <= wb_q - 10'(NODE_DEPTH);
      end
      uft_pkg::DP_DIV_INIT: begin
        quo_q     <= k_q;
        rem_q     <= '0;
        dvs_q     <= (size_q == '0) ? 20'd1 : size_q;
        div_cnt_q <= '0;
      end
      uft_pkg::DP_DIV_STEP: begin
        rem_q     <= trial_ge ? (trial - {1'b0, dvs_q}) : trial;
        quo_q     <= {quo_q[30:0], trial_ge};
        div_cnt_q <= div_cnt_q + 5'd1;
      end
      uft_pkg::DP_LOAD_WR: ra_q <= a_idx;
      uft_pkg::DP_FIND_START: begin
        x_q <= ctl_i.sel_b ? b_idx : a_idx;
        r_q <= ctl_i.sel_b ? b_idx : a_idx;
      end
      uft_pkg::DP_FIND_UP: r_q <= par_rdata_q;
      uft_pkg::DP_SAVE_ROOT: begin
        if (ctl_i.sel_b) rb_q <= r_q;
        else ra_q <= r_q;
      end
      uft_pkg::DP_CMP_WRITE: x_q <= par_rdata_q;
      uft_pkg::DP_EDGE_RDB: begin
        ta_q  <= thr_rdata_q;
        rka_q <= rank_rdata_q;
      end
      uft_pkg::DP_EDGE_CAP: begin
        tb_q  <= thr_rdata_q;
        rkb_q <= rank_rdata_q;
      end
      uft_pkg::DP_DECIDE: begin
        merged_q <= (w_q <= ta_q) && (w_q <= tb_q);
        winb_q   <= (rka_q < rkb_q);
        twin_q   <= (rka_q < rkb_q) ? tb_q : ta_q;
        inc_q    <= (rka_q == rkb_q) && (rka_q != RANK_MAX);
      end
      uft_pkg::DP_LBL_UPD: label_q <= lv_rdata_q ? lb_rdata_q : lbl_cnt_q[9:0];
      default: ;
    endcase
    if (finish) begin
      out_data_q.op_echo       <= op_q;
      out_data_q.merged        <= merged_q;
      out_data_q.root_index    <= 10'(ra_q);
      out_data_q.segment_label <= label_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= uft_pkg::K_RESET;
      lbl_cnt_q   <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) k_q <= cfg_wdata_i;
      if (ctl_i.cmd == uft_pkg::DP_CLEAR) clr_cnt_q <= clr_cnt_q + IW'(1);
      if (ctl_i.cmd == uft_pkg::DP_LBL_UPD && !lv_rdata_q &&
          lbl_cnt_q != uft_pkg::CNT_MAX) begin
        lbl_cnt_q <= lbl_cnt_q + 11'd1;
      end
      if (finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.op        = op_q;
  assign stat_o.wrap_done = ({7'b0, wa_q} < DEPTH_W) && ({7'b0, wb_q} < DEPTH_W);
  assign stat_o.div_last  = (div_cnt_q == 5'd31);
  assign stat_o.up_done   = (par_rdata_q == r_q);
  assign stat_o.x_eq_r    = (x_q == r_q);
  assign stat_o.roots_eq  = (ra_q == rb_q);
  assign stat_o.clr_last  = (clr_cnt_q == IW'(NODE_DEPTH - 1));
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

/* sv/union_find_threshold_merge.sv */
// per word: a load runs the divider and writes the node tables, a query walks node_a to its root,
// an edge walks both ends, skipping the merge on a shared root; an unknown op does no table work
// flow: one word at a time; the next word is taken once its result is registered, which waits
// while the previous result is not taken; the 32-step restoring divider and the parent walks set the pace
// reset: a clearing pass zeroes the label-valid table, no input word is taken until it ends;
// node indices >= NODE_DEPTH are reduced by NODE_DEPTH; configuration writes taken any time
`default_nettype none
`include "union_find_threshold_merge_defines.svh"

module union_find_threshold_merge #(
  parameter int NODE_DEPTH = 1024,
  parameter int RANK_BITS  = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration: k_scale, Q16.16
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  // input words
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire uft_pkg::in_word_t  in_data_i,
  // result words
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output uft_pkg::out_word_t      out_data_o
);

  // command and status between sequencer and datapath
  uft_pkg::dp_ctl_t  ctl;
  uft_pkg::dp_stat_t stat;

  // sequencer: clearing pass, index wrap, dispatch by op, divider, find walks, merge and label steps
  uft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // datapath: node tables, divider, root registers, result register
  uft_datapath #(
    .NODE_DEPTH (NODE_DEPTH),
    .RANK_BITS  (RANK_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .stat_o      (stat)
  );

  // one word in flight: after a take, no new take next cycle
  `UFT_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second word taken while busy")
  // merge flag only on edge results
  `UFT_ASSERT_NOW(a_merge_on_edge, out_valid_o && out_data_o.merged, out_data_o.op_echo == uft_pkg::OP_EDGE, "merge flag on non-edge result")
  // nonzero label only on query results
  `UFT_ASSERT_NOW(a_label_on_query, out_valid_o && (out_data_o.segment_label != 10'd0), out_data_o.op_echo == uft_pkg::OP_QUERY, "label on non-query result")

endmodule

`default_nettype wire
